// ===== hw/rtl/ascf_pkg.sv =====
// ----------------------------------------------------------------------------
// ascf_pkg - shared types and constants of the start code finder
// Request and response payloads, match result bundle, CSR indexes and codes.
// ----------------------------------------------------------------------------
package ascf_pkg;

   // CSR indexes
   localparam logic CSR_MATCH_MODE = 1'b0;
   localparam logic CSR_MARK_BYTE  = 1'b1;

   // match modes
   localparam logic MODE_ANY  = 1'b0;
   localparam logic MODE_MARK = 1'b1;

   // start code bytes and lengths
   localparam logic [7:0] SC_ZERO = 8'h00;
   localparam logic [7:0] SC_ONE  = 8'h01;
   localparam logic [2:0] SC_LEN3 = 3'd3;
   localparam logic [2:0] SC_LEN4 = 3'd4;
   localparam logic [2:0] SC_NONE = 3'd0;

   // a code counts only if it begins more than this far before the buffer end
   localparam logic [16:0] SC_TAIL_ROOM = 17'd4;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [15:0] buffer_length;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] sync_position;
      logic [2:0]  sync_length;
   } rsp_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] position;
      logic [2:0]  length;
   } match_type;

endpackage

// ===== hw/rtl/ascf_detect.sv =====
// ----------------------------------------------------------------------------
// ascf_detect - start code pattern match on the current byte
// Checks the newest byte against the four-byte history window and reports
// whether a counted start code ends here, with its position and length.
// ----------------------------------------------------------------------------
module ascf_detect (
   input  logic [7:0]          data_byte,
   input  logic [31:0]         byte_window,
   input  logic [15:0]         byte_index,
   input  logic [15:0]         buffer_length,
   input  logic                match_mode,
   input  logic [7:0]          mark_byte,
   output ascf_pkg::match_type match
);
   import ascf_pkg::*;

   logic [7:0]  b1, b2, b3, b4;
   logic        any_tail, any_long;
   logic        mark_long, mark_short;
   logic        pat;
   logic [15:0] pos;
   logic [2:0]  len;

   assign b1 = byte_window[7:0];
   assign b2 = byte_window[15:8];
   assign b3 = byte_window[23:16];
   assign b4 = byte_window[31:24];

   // plain mode: 00 00 01 ends at the current byte
   assign any_tail = (byte_index >= 16'd2) && (data_byte == SC_ONE) &&
                     (b1 == SC_ZERO) && (b2 == SC_ZERO);
   assign any_long = (byte_index >= 16'd3) && (b3 == SC_ZERO);

   // mark mode: code followed by the mark byte, long form preferred
   assign mark_long  = (byte_index >= 16'd4) && (data_byte == mark_byte) &&
                       (b1 == SC_ONE) && (b2 == SC_ZERO) && (b3 == SC_ZERO) &&
                       (b4 == SC_ZERO);
   assign mark_short = (byte_index >= 16'd3) && (data_byte == mark_byte) &&
                       (b1 == SC_ONE) && (b2 == SC_ZERO) && (b3 == SC_ZERO);

   always_comb begin
      pat = 1'b0;
      pos = '0;
      len = SC_NONE;
      unique case (match_mode)
         MODE_ANY: begin
            pat = any_tail;
            if (any_long) begin
               pos = byte_index - 16'd3;
               len = SC_LEN4;
            end else begin
               pos = byte_index - 16'd2;
               len = SC_LEN3;
            end
         end
         MODE_MARK: begin
            pat = mark_long || mark_short;
            if (mark_long) begin
               pos = byte_index - 16'd4;
               len = SC_LEN4;
            end else begin
               pos = byte_index - 16'd3;
               len = SC_LEN3;
            end
         end
         default: begin
            pat = 1'b0;
         end
      endcase
   end

   assign match.hit      = pat && (({1'b0, pos} + SC_TAIL_ROOM) < {1'b0, buffer_length});
   assign match.position = pos;
   assign match.length   = len;

endmodule

// ===== hw/rtl/annexb_start_code_finder_unit.sv =====
// A request in the input register has any response registered when it advances.
// Throughput: one request per cycle; the input register refills while the
// response register drains, so a stalled response only blocks once both fill.
// At most one response per buffer: the first counted hit, or not-found at last.
// Reset (synchronous, active high) empties both registers, clears the search
// state and returns match_mode and mark_byte to zero.
// ----------------------------------------------------------------------------
// annexb_start_code_finder_unit - Annex B start code finder, top level
// Scans buffer bytes one per request and reports the first start code
// (00 00 01 or 00 00 00 01), optionally followed by a mark byte.
// ----------------------------------------------------------------------------
module annexb_start_code_finder_unit (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  ascf_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ascf_pkg::rsp_type rsp_data,
   // configuration
   input  logic              csr_wen,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);
   import ascf_pkg::*;

   // configuration registers
   logic        match_mode_ff, match_mode_in;
   logic [7:0]  mark_byte_ff, mark_byte_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   req_type     in_ff, in_in;

   // search state
   logic [31:0] window_ff, window_in;
   logic [15:0] index_ff, index_in;
   logic        done_ff, done_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   // stage control
   logic        advance;
   logic        rsp_load;
   logic [31:0] eff_window;
   logic [15:0] eff_index;
   logic        eff_done;
   match_type   match;

   // ---- configuration writes ----
   always_comb begin
      match_mode_in = match_mode_ff;
      mark_byte_in  = mark_byte_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_MATCH_MODE: match_mode_in = csr_wdata[0];
            CSR_MARK_BYTE:  mark_byte_in  = csr_wdata;
            default:        match_mode_in = match_mode_ff;
         endcase
      end
   end

   // ---- handshake ----
   // Advance the input register whenever the response slot is free or drains
   // this cycle; accept a new request whenever the input register is empty or moves on.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_in       = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // ---- search ----
   // First byte of a buffer sees a clean window, index and done flag.
   assign eff_window = in_ff.first_byte ? '0   : window_ff;
   assign eff_index  = in_ff.first_byte ? '0   : index_ff;
   assign eff_done   = in_ff.first_byte ? 1'b0 : done_ff;

   ascf_detect u_detect (
      .data_byte     (in_ff.data_byte),
      .byte_window   (eff_window),
      .byte_index    (eff_index),
      .buffer_length (in_ff.buffer_length),
      .match_mode    (match_mode_ff),
      .mark_byte     (mark_byte_ff),
      .match         (match)
   );

   // A request issues a response on a hit, or on the last byte without one.
   assign rsp_load = advance && !eff_done && (match.hit || in_ff.last_byte);

   always_comb begin
      window_in = window_ff;
      index_in  = index_ff;
      done_in   = done_ff;
      // once done, hold everything until the next first byte
      if (advance && !eff_done) begin
         window_in = {eff_window[23:0], in_ff.data_byte};
         index_in  = (eff_index == 16'hFFFF) ? eff_index : eff_index + 16'd1;
         done_in   = match.hit || in_ff.last_byte;
      end
   end

   // ---- response register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (match.hit) begin
            rsp_in.found         = 1'b1;
            rsp_in.sync_position = match.position;
            rsp_in.sync_length   = match.length;
         end else begin
            rsp_in.found         = 1'b0;
            rsp_in.sync_position = '0;
            rsp_in.sync_length   = SC_NONE;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         match_mode_ff <= MODE_ANY;
         mark_byte_ff  <= '0;
         in_valid_ff   <= 1'b0;
         window_ff     <= '0;
         index_ff      <= '0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         match_mode_ff <= match_mode_in;
         mark_byte_ff  <= mark_byte_in;
         in_valid_ff   <= in_valid_in;
         window_ff     <= window_in;
         index_ff      <= index_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   // ---- checks ----
`ifndef SYNTHESIS
   // a not-found response carries zero position and length
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |-> rsp_ff.sync_position == 16'd0 &&
                                        rsp_ff.sync_length == SC_NONE)
      else $error("not-found response with nonzero position or length");

   // a hit reports a three- or four-byte code
   a_found_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> rsp_ff.sync_length == SC_LEN3 ||
                                       rsp_ff.sync_length == SC_LEN4)
      else $error("hit response with bad start code length");

   // issuing a response closes the search for this buffer
   a_done_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> done_ff)
      else $error("search left open after a response");

   // a waiting response is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending response lost or changed");
`endif

endmodule
